// ----- src/dssm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the dual stack shared memory unit.
// No dependencies; used by the controller, the datapath and the top level.
package dssm_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_A = 3'd0,
      OP_PUSH_B = 3'd1,
      OP_POP_A  = 3'd2,
      OP_POP_B  = 3'd3,
      OP_DUMP_A = 3'd4,
      OP_DUMP_B = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_READ = 2'd2,
      S_RESP = 2'd3
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic load_read;
      logic advance;
   } cmd_type;

   typedef struct packed {
      logic op_valid;
      logic go_read;
      logic more;
   } stat_type;

endpackage

// ----- src/dssm_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine for the dual stack shared memory unit.
// Depends on dssm_pkg; drives the datapath through cmd_type, reads stat_type.
module dssm_ctrl
   import dssm_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!stat.op_valid) begin
               state_in = S_IDLE;
            end else if (stat.go_read) begin
               state_in = S_READ;
            end else begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = stat.more ? S_READ : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready     = (state_ff == S_IDLE);
      rsp_valid     = (state_ff == S_RESP);
      cmd.capture   = (state_ff == S_IDLE) && req_valid;
      cmd.exec      = (state_ff == S_EXEC);
      cmd.load_read = (state_ff == S_READ);
      cmd.advance   = (state_ff == S_RESP) && rsp_ready && stat.more;
   end

endmodule

// ----- src/dssm_dpath.sv -----
`timescale 1ns / 1ps
// Datapath for the dual stack shared memory unit: stack counts, shared
// memory, dump pointer and result register. Depends on dssm_pkg.
module dssm_dpath
   import dssm_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_push_value,
   input  cmd_type            cmd,
   output stat_type           stat,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value,
   output logic               rsp_last
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0]  ONE_C   = CNT_W'(1);
   localparam logic [ADDR_W-1:0] LAST_C  = ADDR_W'(DEPTH - 1);

   logic [2:0]         op_ff;
   logic signed [31:0] val_ff;
   logic [CNT_W-1:0]   count_a_ff, count_a_in;
   logic [CNT_W-1:0]   count_b_ff, count_b_in;
   logic [ADDR_W-1:0]  ptr_ff, ptr_in;
   logic signed [31:0] store_ff [DEPTH];
   logic signed [31:0] rd_data_ff;
   status_type         rsp_status_ff, rsp_status_in;
   logic signed [31:0] rsp_value_ff, rsp_value_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               wr_en, rd_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [CNT_W:0]     fill_sum;
   logic               full, sel_a, empty;
   logic               is_push, is_pop, is_dump;
   logic [CNT_W-1:0]   sel_cnt, top_a, top_b, push_b;
   logic [ADDR_W-1:0]  top_addr, ptr_next;
   logic               ptr_end;

   always_comb begin
      fill_sum = {1'b0, count_a_ff} + {1'b0, count_b_ff};
      full     = (fill_sum >= {1'b0, DEPTH_C});
      sel_a    = op_ff inside {OP_PUSH_A, OP_POP_A, OP_DUMP_A};
      is_push  = op_ff inside {OP_PUSH_A, OP_PUSH_B};
      is_pop   = op_ff inside {OP_POP_A, OP_POP_B};
      is_dump  = op_ff inside {OP_DUMP_A, OP_DUMP_B};
      sel_cnt  = sel_a ? count_a_ff : count_b_ff;
      empty    = (sel_cnt == '0);
      top_a    = count_a_ff - ONE_C;
      top_b    = DEPTH_C - count_b_ff;
      push_b   = top_b - ONE_C;
      top_addr = sel_a ? top_a[ADDR_W-1:0] : top_b[ADDR_W-1:0];
      ptr_next = sel_a ? ptr_ff - ADDR_W'(1) : ptr_ff + ADDR_W'(1);
      ptr_end  = sel_a ? (ptr_ff == '0) : (ptr_ff == LAST_C);

      stat.op_valid = is_push || is_pop || is_dump;
      stat.go_read  = (is_pop || is_dump) && !empty;
      stat.more     = is_dump && !rsp_last_ff;
   end

   always_comb begin
      count_a_in    = count_a_ff;
      count_b_in    = count_b_ff;
      ptr_in        = ptr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = count_a_ff[ADDR_W-1:0];
      rd_en         = 1'b0;
      rd_addr       = top_addr;

      if (cmd.exec) begin
         if (is_push) begin
            rsp_value_in = '0;
            rsp_last_in  = 1'b1;
            if (full) begin
               rsp_status_in = ST_OVERFLOW;
            end else begin
               rsp_status_in = ST_OK;
               wr_en         = 1'b1;
               if (sel_a) begin
                  wr_addr    = count_a_ff[ADDR_W-1:0];
                  count_a_in = count_a_ff + ONE_C;
               end else begin
                  wr_addr    = push_b[ADDR_W-1:0];
                  count_b_in = count_b_ff + ONE_C;
               end
            end
         end else if (is_pop || is_dump) begin
            if (empty) begin
               rsp_status_in = is_pop ? ST_UNDERFLOW : ST_EMPTY;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
            end else begin
               rd_en  = 1'b1;
               ptr_in = top_addr;
               if (is_pop) begin
                  if (sel_a) begin
                     count_a_in = count_a_ff - ONE_C;
                  end else begin
                     count_b_in = count_b_ff - ONE_C;
                  end
               end
            end
         end
      end

      if (cmd.load_read) begin
         rsp_status_in = ST_OK;
         rsp_value_in  = rd_data_ff;
         rsp_last_in   = is_pop || ptr_end;
      end

      if (cmd.advance) begin
         ptr_in  = ptr_next;
         rd_en   = 1'b1;
         rd_addr = ptr_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else begin
         count_a_ff <= count_a_in;
         count_b_ff <= count_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_op;
         val_ff <= req_push_value;
      end
      ptr_ff        <= ptr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_sum <= {1'b0, DEPTH_C})
      else $error("stack counts exceed memory depth");

   a_overflow_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && is_push && full) |=> ($stable(count_a_ff) && $stable(count_b_ff)))
      else $error("overflowed push changed a stack count");

   a_advance_not_last: assert property (@(posedge clock) disable iff (reset)
      cmd.advance |-> (is_dump && !rsp_last_ff))
      else $error("dump advanced past its final beat");
`endif

endmodule

// ----- src/dual_stack_shared_memory_unit.sv -----
`timescale 1ns / 1ps
// Top level of the dual stack shared memory unit: two stacks in one memory.
// Depends on dssm_pkg, dssm_ctrl and dssm_dpath.
//
//   channel  ports                                   direction
//   request  req_valid req_ready req_op req_push_value  in
//   response rsp_valid rsp_ready rsp_status rsp_value rsp_last  out
//
// Push: accepted in S_IDLE, executed in S_EXEC, result beat in S_RESP; a pop that finds its stack non-empty
// also passes through S_READ (registered memory read). Dump: first beat as for pop, then S_READ again per further beat.
// Unused op codes are dropped in S_EXEC with no beat.
// One item in flight; req_ready stays low until the final beat of an item is taken.
// Synchronous reset clears both stack counts at once; memory contents are not cleared.
module dual_stack_shared_memory_unit
   import dssm_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_value,
   output logic               rsp_last
);

   cmd_type  cmd;
   stat_type stat;

   dssm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dssm_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_status     (rsp_status),
      .rsp_value      (rsp_value),
      .rsp_last       (rsp_last)
   );

endmodule
